FILE: rtl/repeat_fingerprint_table_macros.svh
// Assertion macros shared by the fingerprint table modules.
`ifndef REPEAT_FINGERPRINT_TABLE_MACROS_SVH
`define REPEAT_FINGERPRINT_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RFT_ASSERT(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("rft assertion failed");

`define RFT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rft implication failed");

`define RFT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rft next-cycle check failed");

`else

`define RFT_ASSERT(label, clk, rstn, expr)
`define RFT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RFT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/rft_pkg.sv
package rft_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_W = 32;
    localparam int KEYS_W = 3 * KEY_W;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

    typedef enum logic [1:0] {
        OUTCOME_ZERO   = 2'd0,
        OUTCOME_HIT    = 2'd1,
        OUTCOME_INSERT = 2'd2,
        OUTCOME_FLUSH  = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     in_take;
        logic     scan_start;
        logic     clear_run;
        logic     search_run;
        logic     flush_run;
        logic     wr_hit;
        logic     wr_insert;
        logic     res_load;
        outcome_t res_sel;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic key_zero;
        logic scan_done;
        logic hit_found;
        logic free_found;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/rft_ram.sv
module rft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rft_datapath.sv
`include "repeat_fingerprint_table_macros.svh"

module rft_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rft_pkg::ctrl_cmd_t             cmd,
    output rft_pkg::dp_status_t            status,
    input  logic [rft_pkg::KEYS_W-1:0]     s_tdata,
    input  logic                           cfg_valid,
    input  logic [rft_pkg::COUNT_W-1:0]    cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,
    output logic [1:0]                     m_tuser
);

    localparam int IW = rft_pkg::IDX_W;
    localparam int CW = rft_pkg::CNT_W;
    localparam int NW = rft_pkg::COUNT_W;
    localparam logic [CW-1:0] LAST = CW'(rft_pkg::TABLE_ENTRIES);

    logic [rft_pkg::KEYS_W-1:0] key_reg;
    logic [NW-1:0]              limit_reg;
    logic [CW-1:0]              scan_cnt_reg, scan_cnt_next;
    logic                       rd_valid_reg;
    logic [IW-1:0]              rd_idx_reg;
    logic                       hit_found_reg, hit_found_next;
    logic [IW-1:0]              hit_idx_reg, hit_idx_next;
    logic [NW-1:0]              hit_cnt_reg, hit_cnt_next;
    logic                       free_found_reg, free_found_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;
    logic                       res_rep_reg;
    rft_pkg::outcome_t          res_outcome_reg;
    logic [NW-1:0]              res_count_reg;
    logic                       m_tvalid_reg;
    logic                       m_rep_reg;
    rft_pkg::outcome_t          m_outcome_reg;
    logic [NW-1:0]              m_count_reg;

    logic                       scan_open;
    logic                       rd_en;
    logic [rft_pkg::KEYS_W-1:0] rd_key;
    logic [NW-1:0]              rd_cnt;
    logic                       cnt_wr_en;
    logic [IW-1:0]              cnt_wr_addr;
    logic [NW-1:0]              cnt_wr_data;
    logic                       search_eval;
    logic                       flush_clear;
    logic [NW-1:0]              hit_after;

    assign scan_open   = (scan_cnt_reg != LAST);
    assign rd_en       = scan_open && ((cmd.search_run && !hit_found_reg) || cmd.flush_run);
    assign search_eval = cmd.search_run && rd_valid_reg && !hit_found_reg;
    assign flush_clear = cmd.flush_run && rd_valid_reg && (rd_cnt <= limit_reg);
    assign hit_after   = (hit_cnt_reg == rft_pkg::COUNT_MAX) ? rft_pkg::COUNT_MAX
                                                             : hit_cnt_reg + NW'(1);

    always_comb begin
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = scan_cnt_reg[IW-1:0];
        cnt_wr_data = '0;
        if (cmd.clear_run && scan_open) begin
            cnt_wr_en = 1'b1;
        end else if (cmd.wr_hit) begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = hit_idx_reg;
            cnt_wr_data = hit_after;
        end else if (cmd.wr_insert) begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = free_idx_reg;
            cnt_wr_data = NW'(1);
        end else if (flush_clear) begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = rd_idx_reg;
        end
    end

    always_comb begin
        scan_cnt_next   = scan_cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (cmd.scan_start) begin
            scan_cnt_next   = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end else begin
            if ((cmd.clear_run && scan_open) || rd_en) begin
                scan_cnt_next = scan_cnt_reg + CW'(1);
            end
            if (search_eval) begin
                if (rd_cnt != '0 && rd_key == key_reg) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_reg;
                    hit_cnt_next   = rd_cnt;
                end
                if (rd_cnt == '0 && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            limit_reg      <= rft_pkg::LIMIT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            scan_cnt_reg   <= scan_cnt_next;
            rd_valid_reg   <= rd_en && !cmd.scan_start;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= scan_cnt_reg[IW-1:0];
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        free_idx_reg <= free_idx_next;
        if (cmd.in_take) begin
            key_reg <= s_tdata;
        end
        if (cmd.res_load) begin
            res_outcome_reg <= cmd.res_sel;
            case (cmd.res_sel)
                rft_pkg::OUTCOME_HIT: begin
                    res_rep_reg   <= (hit_cnt_reg >= limit_reg);
                    res_count_reg <= hit_after;
                end
                rft_pkg::OUTCOME_INSERT: begin
                    res_rep_reg   <= 1'b0;
                    res_count_reg <= NW'(1);
                end
                default: begin
                    res_rep_reg   <= 1'b0;
                    res_count_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            m_rep_reg     <= res_rep_reg;
            m_outcome_reg <= res_outcome_reg;
            m_count_reg   <= res_count_reg;
        end
    end

    rft_ram #(
        .WIDTH (rft_pkg::KEYS_W),
        .DEPTH (rft_pkg::TABLE_ENTRIES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_insert),
        .wr_addr (free_idx_reg),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[IW-1:0]),
        .rd_data (rd_key)
    );

    rft_ram #(
        .WIDTH (NW),
        .DEPTH (rft_pkg::TABLE_ENTRIES)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[IW-1:0]),
        .rd_data (rd_cnt)
    );

    assign status.key_zero   = (key_reg == '0);
    assign status.scan_done  = !scan_open && !rd_valid_reg;
    assign status.hit_found  = hit_found_reg;
    assign status.free_found = free_found_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_rep_reg};
    assign m_tuser  = m_outcome_reg;

    `RFT_ASSERT_IMP(a_no_count_write_in_search, aclk, aresetn, cmd.search_run, !cnt_wr_en)
    `RFT_ASSERT_IMP(a_hit_entry_used, aclk, aresetn,
                    cmd.res_load && cmd.res_sel == rft_pkg::OUTCOME_HIT, hit_cnt_reg != '0)
    `RFT_ASSERT(a_scan_in_range, aclk, aresetn, scan_cnt_reg <= LAST)

endmodule

FILE: rtl/rft_controller.sv
`include "repeat_fingerprint_table_macros.svh"

module rft_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rft_pkg::dp_status_t  status,
    output rft_pkg::ctrl_cmd_t   cmd
);

    rft_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rft_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = rft_pkg::OUTCOME_ZERO;
        s_tready    = 1'b0;
        case (state_reg)
            rft_pkg::ST_CLEAR: begin
                if (status.scan_done) begin
                    state_next = rft_pkg::ST_IDLE;
                end else begin
                    cmd.clear_run = 1'b1;
                end
            end
            rft_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_take    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = rft_pkg::ST_SEARCH;
                end
            end
            rft_pkg::ST_SEARCH: begin
                if (status.key_zero) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = rft_pkg::OUTCOME_ZERO;
                    state_next   = rft_pkg::ST_DONE;
                end else if (status.hit_found) begin
                    cmd.wr_hit   = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = rft_pkg::OUTCOME_HIT;
                    state_next   = rft_pkg::ST_DONE;
                end else if (status.scan_done) begin
                    if (status.free_found) begin
                        cmd.wr_insert = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_sel   = rft_pkg::OUTCOME_INSERT;
                        state_next    = rft_pkg::ST_DONE;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = rft_pkg::ST_FLUSH;
                    end
                end else begin
                    cmd.search_run = 1'b1;
                end
            end
            rft_pkg::ST_FLUSH: begin
                if (status.scan_done) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = rft_pkg::OUTCOME_FLUSH;
                    state_next   = rft_pkg::ST_DONE;
                end else begin
                    cmd.flush_run = 1'b1;
                end
            end
            rft_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = rft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rft_pkg::ST_CLEAR;
            end
        endcase
    end

    `RFT_ASSERT_NEXT(a_accept_starts_search, aclk, aresetn,
                     s_tvalid && s_tready, state_reg == rft_pkg::ST_SEARCH)
    `RFT_ASSERT_NEXT(a_zero_key_finishes, aclk, aresetn,
                     state_reg == rft_pkg::ST_SEARCH && status.key_zero,
                     state_reg == rft_pkg::ST_DONE)
    `RFT_ASSERT(a_single_scan_cmd, aclk, aresetn,
                $onehot0({cmd.clear_run, cmd.search_run, cmd.flush_run}))

endmodule

FILE: rtl/repeat_fingerprint_table.sv
// Repeat detector over three-word fingerprints, held in a table of
// rft_pkg::TABLE_ENTRIES entries (64) in a key memory and a count memory, each with one
// write and one registered read port. After reset the block first runs a clearing pass
// over the count memory and takes no beat until it ends. Each item is then worked alone:
// a zero fingerprint gives its result without a search, a hit ends the search at the hit
// entry, an insert follows a search of the whole table, and a full table is flushed in a
// second walk. The search and the flush each walk the table one entry per cycle through
// the read port. A finished result waits in the output register while the next input
// beat is accepted. The repeat limit may be written through the cfg port at any time the
// block is idle.
module repeat_fingerprint_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key_first[31:0], key_second[63:32], key_third[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // is_repeat[0], hit_count[8:1], zero fill[15:9]
    output logic [1:0]  m_tuser,   // outcome[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // repeat_limit[7:0]
);

    rft_pkg::ctrl_cmd_t  cmd;
    rft_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rft_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rft_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
